### src/lrupr_pkg.sv
package lrupr_pkg;

	// Table geometry.
	localparam int FRAMES    = 16;
	localparam int PAGE_BITS = 16;
	localparam int TIME_BITS = 32;

	// Derived widths.
	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CNT_W  = $clog2(FRAMES + 1);
	localparam int CFG_W  = 5;
	localparam int SLOT_W = 4;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [PAGE_BITS-1:0] page_t;
	typedef logic [TIME_BITS-1:0] stamp_t;

	localparam stamp_t STAMP_MAX = '1;

	// Search record that walks down the row of frame cells.
	typedef struct packed {
		logic   go;
		page_t  page;
		logic   hit;
		idx_t   hit_idx;
		logic   empty;
		idx_t   empty_idx;
		logic   have_old;
		stamp_t oldest;
		idx_t   old_idx;
	} srch_t;

	// Update command broadcast to all cells at the end of a scan.
	typedef struct packed {
		logic   en;
		logic   load;
		idx_t   idx;
		page_t  page;
		stamp_t stamp;
	} wr_t;

endpackage

### src/lrupr_cell.sv
module lrupr_cell import lrupr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  idx_t  cell_idx,
	input  cnt_t  active_n,
	input  srch_t rec_in,
	output srch_t rec_out,
	input  wr_t   wr
);

	page_t  page_q;
	stamp_t stamp_q;
	logic   valid_q;
	srch_t  rec_q;
	srch_t  rec_nxt;
	logic   active;
	logic   sel;

	assign active = (CNT_W'(cell_idx) < active_n);
	assign sel    = wr.en && (wr.idx == cell_idx);

	// Fold this frame into the passing search record.
	always_comb begin
		rec_nxt = rec_in;
		if (active && valid_q) begin
			if (!rec_in.hit && (page_q == rec_in.page)) begin
				rec_nxt.hit     = 1'b1;
				rec_nxt.hit_idx = cell_idx;
			end
			if (!rec_in.have_old || (stamp_q < rec_in.oldest)) begin
				rec_nxt.have_old = 1'b1;
				rec_nxt.oldest   = stamp_q;
				rec_nxt.old_idx  = cell_idx;
			end
		end
		if (active && !valid_q && !rec_in.empty) begin
			rec_nxt.empty     = 1'b1;
			rec_nxt.empty_idx = cell_idx;
		end
	end

	// Hand the record to the next cell and track the valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			rec_q <= rec_nxt;
			if (sel && wr.load) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Frame contents: page on a load, timestamp on every access.
	always_ff @(posedge clk) begin
		if (sel) begin
			stamp_q <= wr.stamp;
			if (wr.load) begin
				page_q <= wr.page;
			end
		end
	end

	assign rec_out = rec_q;

endmodule

### src/lru_page_replacement_unit.sv
// Channel   Signals                              Direction
// input     in_valid, in_ready, page_number      into block
// result    out_valid, out_ready, fault,         out of block
//           frame_slot
// config    cfg_valid, cfg_ready, frames_in_use  into block
//
// For each page reference the search record steps through one frame cell per
// cycle, then the chosen frame is written once the record leaves the last cell.
// A new reference is taken as soon as the previous one has committed, while
// its result may still wait in the output register.
// Reset clears all frame valid bits and the access clock at once; no sweep.
// A stalled result holds the block after one more commit until it is taken.
module lru_page_replacement_unit import lrupr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [15:0]       page_number,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              fault,
	output logic [SLOT_W-1:0] frame_slot,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  frames_in_use
);

	logic              busy_q;
	logic [CFG_W-1:0]  cfg_q;
	stamp_t            clk_q;
	logic              out_valid_q;
	logic              fault_q;
	logic [SLOT_W-1:0] slot_q;
	logic              pend_v_q;
	logic              pend_fault_q;
	logic [SLOT_W-1:0] pend_slot_q;

	logic              in_acc;
	cnt_t              active_n;
	srch_t             chain [FRAMES+1];
	srch_t             fin;
	wr_t               wr;
	logic              res_fault;
	logic [SLOT_W-1:0] res_slot;
	logic              out_free;

	assign in_ready  = !busy_q && !pend_v_q;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cfg_q <= frames_in_use;
		end
	end

	// Clamp the frame count into one through FRAMES.
	always_comb begin
		if (cfg_q == '0) begin
			active_n = CNT_W'(1);
		end else if (int'(cfg_q) > FRAMES) begin
			active_n = CNT_W'(FRAMES);
		end else begin
			active_n = CNT_W'(cfg_q);
		end
	end

	// Launch a fresh search record into the first cell.
	always_comb begin
		chain[0]      = '0;
		chain[0].go   = in_acc;
		chain[0].page = PAGE_BITS'(page_number);
	end

	// Row of frame cells.
	for (genvar g = 0; g < FRAMES; g++) begin : g_cell
		lrupr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (IDX_W'(g)),
			.active_n (active_n),
			.rec_in   (chain[g]),
			.rec_out  (chain[g+1]),
			.wr       (wr)
		);
	end

	assign fin = chain[FRAMES];

	// Pick the frame once the record leaves the last cell.
	always_comb begin
		wr.en    = fin.go;
		wr.load  = !fin.hit;
		wr.page  = fin.page;
		wr.stamp = clk_q;
		if (fin.hit) begin
			wr.idx = fin.hit_idx;
		end else if (fin.empty) begin
			wr.idx = fin.empty_idx;
		end else begin
			wr.idx = fin.old_idx;
		end
	end

	assign res_fault = !fin.hit;
	assign res_slot  = SLOT_W'(wr.idx);
	assign out_free  = !out_valid_q || out_ready;

	// Busy flag, access clock and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			clk_q        <= '0;
			out_valid_q  <= 1'b0;
			fault_q      <= 1'b0;
			slot_q       <= '0;
			pend_v_q     <= 1'b0;
			pend_fault_q <= 1'b0;
			pend_slot_q  <= '0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (fin.go) begin
				busy_q <= 1'b0;
			end
			if (fin.go && (clk_q != STAMP_MAX)) begin
				clk_q <= clk_q + 1'b1;
			end
			if (out_free) begin
				if (pend_v_q) begin
					out_valid_q <= 1'b1;
					fault_q     <= pend_fault_q;
					slot_q      <= pend_slot_q;
					pend_v_q    <= 1'b0;
				end else if (fin.go) begin
					out_valid_q <= 1'b1;
					fault_q     <= res_fault;
					slot_q      <= res_slot;
				end else begin
					out_valid_q <= 1'b0;
				end
			end else if (fin.go) begin
				pend_v_q     <= 1'b1;
				pend_fault_q <= res_fault;
				pend_slot_q  <= res_slot;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign fault      = fault_q;
	assign frame_slot = slot_q;

	// A search only finishes while a transaction is in flight.
	a_fin_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin.go |-> busy_q)
		else $error("search finished with no transaction in flight");

	// A pending result only exists behind a full output register.
	a_pend_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> (out_valid_q && !in_ready))
		else $error("pending result without full output stage");

	// The access clock moves by one per commit until it saturates.
	a_clk_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fin.go && (clk_q != STAMP_MAX)) |=> (clk_q == $past(clk_q) + 1'b1))
		else $error("access clock did not advance on commit");

	// Without a commit the access clock holds.
	a_clk_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fin.go |=> $stable(clk_q))
		else $error("access clock moved without a commit");

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import lrupr_pkg::*;

	// One expected result: hit or fault, and the frame that was used.
	typedef struct packed {
		logic              fault;
		logic [SLOT_W-1:0] slot;
	} outcome_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              in_valid      = 1'b0;
	logic              in_ready;
	logic [15:0]       page_number   = '0;
	logic              out_valid;
	logic              out_ready     = 1'b0;
	logic              fault;
	logic [SLOT_W-1:0] frame_slot;
	logic              cfg_valid     = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  frames_in_use = CFG_RESET;

	// Shadow copy of the frame table, the access clock and the frame count.
	page_t            shadow_page [FRAMES];
	logic             shadow_valid [FRAMES];
	stamp_t           shadow_stamp [FRAMES];
	stamp_t           shadow_clock;
	logic [CFG_W-1:0] shadow_limit;

	outcome_t pending_outcomes [$];
	int       errors       = 0;
	bit       no_idle      = 1'b0;
	int       hold_request = 0;
	int       hold_left    = 0;
	int       stall_left   = 0;

	lru_page_replacement_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.page_number   (page_number),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fault         (fault),
		.frame_slot    (frame_slot),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.frames_in_use (frames_in_use)
	);

	// 50 MHz clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Reset state of the shadow table.
	task automatic clear_shadow();
		for (int i = 0; i < FRAMES; i++) begin
			shadow_page[i]  = '0;
			shadow_valid[i] = 1'b0;
			shadow_stamp[i] = '0;
		end
		shadow_clock = '0;
		shadow_limit = CFG_RESET;
	endtask

	// Looks up one page reference, updates the shadow table and returns the
	// expected outcome. A hit refreshes the stamp; a miss loads the first empty
	// frame, or else the oldest frame with the lowest index on ties.
	function automatic outcome_t lookup_and_load(input page_t pg);
		int       n;
		int       victim;
		bit       have_old;
		stamp_t   oldest;
		stamp_t   now;
		outcome_t res;
		n = (shadow_limit == 0) ? 1 : (shadow_limit > FRAMES) ? FRAMES : int'(shadow_limit);
		now = shadow_clock;
		if (shadow_clock != STAMP_MAX)
			shadow_clock = shadow_clock + 1'b1;
		for (int i = 0; i < n; i++) begin
			if (shadow_valid[i] && shadow_page[i] == pg) begin
				shadow_stamp[i] = now;
				res.fault = 1'b0;
				res.slot  = SLOT_W'(i);
				return res;
			end
		end
		victim   = 0;
		have_old = 1'b0;
		oldest   = '0;
		for (int i = 0; i < n; i++) begin
			if (!shadow_valid[i]) begin
				victim = i;
				break;
			end
			if (!have_old || shadow_stamp[i] < oldest) begin
				oldest   = shadow_stamp[i];
				victim   = i;
				have_old = 1'b1;
			end
		end
		shadow_page[victim]  = pg;
		shadow_valid[victim] = 1'b1;
		shadow_stamp[victim] = now;
		res.fault = 1'b1;
		res.slot  = SLOT_W'(victim);
		return res;
	endfunction

	// Sender gap: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < 50)
			$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	// Sends one page reference and records its expected outcome on acceptance.
	task automatic send_page(input page_t pg);
		int gap;
		page_number <= pg;
		in_valid    <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_outcomes.push_back(lookup_and_load(pg));
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every expected result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
	endtask

	// Writes the frame count while the block is idle.
	task automatic write_limit(input logic [CFG_W-1:0] value);
		wait_drained();
		frames_in_use <= value;
		cfg_valid     <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		shadow_limit  = value;
	endtask

	// Receiver: long hold-offs on request, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 99) < 12) begin
			stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) :
				$urandom_range(9, 39);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compares each result transaction with the oldest expected outcome.
	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("result transaction with no reference outstanding");
			end else begin
				want = pending_outcomes.pop_front();
				if (fault !== want.fault)
					report_mismatch($sformatf("fault %b, expected %b", fault, want.fault));
				if (frame_slot !== want.slot)
					report_mismatch($sformatf("frame_slot %0d, expected %0d",
						frame_slot, want.slot));
			end
		end
	end

	// First references after reset, with all sixteen frames in use.
	task automatic test_first_references();
		send_page(16'h0000);
		send_page(16'hFFFF);
		send_page(16'h0000);
		send_page(16'hFFFF);
	endtask

	// Two frames: hits and eviction of the least recently used one.
	task automatic test_two_frames();
		write_limit(5'd2);
		send_page(16'hFFFF);
		send_page(16'h1234);
		send_page(16'h0000);
		send_page(16'h1234);
	endtask

	// A count of zero behaves as a single frame.
	task automatic test_zero_count();
		write_limit(5'd0);
		send_page(16'h5555);
		send_page(16'hAAAA);
		send_page(16'hAAAA);
	endtask

	// A count above the table size uses the whole table, and frames that were
	// outside the count keep their pages.
	task automatic test_count_above_table();
		write_limit(5'd31);
		send_page(16'h0000);
		send_page(16'h1234);
		send_page(16'h8001);
		send_page(16'h7FFE);
	endtask

	// The receiver holds off long enough that the block fills and stalls input.
	task automatic test_output_backpressure();
		write_limit(5'd16);
		no_idle      = 1'b1;
		hold_request = 400;
		for (int i = 0; i < 14; i++)
			send_page(page_t'($urandom_range(0, 7)));
		no_idle = 1'b0;
		wait_drained();
	endtask

	// The sender stops until every result is back, then resumes.
	task automatic test_pause_until_empty();
		for (int r = 0; r < 3; r++) begin
			for (int i = 0; i < 4; i++)
				send_page(page_t'($urandom_range(0, 20)));
			wait_drained();
		end
	endtask

	// Random phases: each picks a frame count and a pool of pages somewhat
	// larger than the frames in use, so hits, fills and evictions all occur.
	task automatic test_random_traffic();
		logic [CFG_W-1:0] lim;
		int               eff;
		int               pool_n;
		int               count;
		page_t            pool [];
		for (int p = 0; p < 22; p++) begin
			case (p)
				0:       lim = 5'd0;
				1:       lim = 5'd1;
				2:       lim = 5'd2;
				3:       lim = 5'd16;
				4:       lim = 5'd17;
				5:       lim = 5'd31;
				default: lim = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31)) :
					CFG_W'($urandom_range(1, 16));
			endcase
			write_limit(lim);
			no_idle = (p % 5 == 3);
			eff     = (lim == 0) ? 1 : (lim > FRAMES) ? FRAMES : int'(lim);
			pool_n  = eff + $urandom_range(1, eff + 2);
			pool    = new[pool_n];
			foreach (pool[i])
				pool[i] = page_t'($urandom);
			count = $urandom_range(55, 85);
			for (int i = 0; i < count; i++) begin
				if ($urandom_range(0, 99) < 85)
					send_page(pool[$urandom_range(0, pool_n - 1)]);
				else
					send_page(page_t'($urandom));
			end
			no_idle = 1'b0;
		end
	endtask

	initial begin
		clear_shadow();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_references();
		test_two_frames();
		test_zero_count();
		test_count_above_table();
		test_output_backpressure();
		test_pause_until_empty();
		test_random_traffic();
		wait_drained();
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Watchdog for a hung block.
	initial begin
		#15_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
